@@ hdl/nptd_pkg.sv @@
// shared types and constants of the nested priority task dispatcher
`timescale 1ns / 1ps
`default_nettype none

package nptd_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int NEST_DEPTH_DEF  = 16;
   localparam int DATA_W          = 8;
   localparam int COUNT_OUT_W     = 5;
   localparam int STATUS_W        = 2;

   localparam logic KIND_ADD    = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IDLE_FINISH = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] prio;
      logic [DATA_W-1:0] id;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_SHIFT_IN,
      OP_SHIFT_OUT
   } cell_op_type;

   // control handed to every queue cell
   typedef struct packed {
      cell_op_type       op;
      logic [DATA_W-1:0] new_prio;
   } queue_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_START
   } state_type;

endpackage

`default_nettype wire

@@ hdl/nptd_queue_cell.sv @@
// one slot of the sorted pending queue, shift-insert and shift-out
`timescale 1ns / 1ps
`default_nettype none

module nptd_queue_cell (
   input  wire logic                  clock,
   input  wire nptd_pkg::queue_ctl_type ctl,
   input  wire nptd_pkg::entry_type   new_entry,
   input  wire logic                  occupied,
   input  wire logic                  left_after,
   input  wire nptd_pkg::entry_type   left_entry,
   input  wire nptd_pkg::entry_type   right_entry,
   output nptd_pkg::entry_type        entry,
   output logic                       after
);

   nptd_pkg::entry_type entry_ff;
   nptd_pkg::entry_type entry_in;

   // new task goes behind every queued task of equal or smaller value
   assign after = occupied && (entry_ff.prio <= ctl.new_prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         nptd_pkg::OP_SHIFT_IN: begin
            if (after) begin
               entry_in = entry_ff;
            end else if (left_after) begin
               entry_in = new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
         nptd_pkg::OP_SHIFT_OUT: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

@@ hdl/nptd_stack_cell.sv @@
// one slot of the running-priority stack, top of stack in slot zero
`timescale 1ns / 1ps
`default_nettype none

module nptd_stack_cell (
   input  wire logic                        clock,
   input  wire nptd_pkg::cell_op_type       op,
   input  wire logic [nptd_pkg::DATA_W-1:0] left_prio,
   input  wire logic [nptd_pkg::DATA_W-1:0] right_prio,
   output logic [nptd_pkg::DATA_W-1:0]      prio
);

   logic [nptd_pkg::DATA_W-1:0] prio_ff;
   logic [nptd_pkg::DATA_W-1:0] prio_in;

   assign prio = prio_ff;

   always_comb begin
      case (op)
         nptd_pkg::OP_SHIFT_IN:  prio_in = left_prio;
         nptd_pkg::OP_SHIFT_OUT: prio_in = right_prio;
         default:                prio_in = prio_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
   end

endmodule

`default_nettype wire

@@ hdl/nested_priority_task_dispatcher.sv @@
// top level: event sequencer over the queue cell chain and the stack cell chain
// rsp_valid is set at the start edge, once ST_START finds the output register free
// a new transaction is taken only after the start check of the last one;
//   req_stall stays up in ST_START, after the cell chain edit on acceptance
// a finished result waits in the output register while the next transaction is taken
// reset: queue and stack empty, no result pending; cell contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module nested_priority_task_dispatcher #(
   parameter int QUEUE_DEPTH = nptd_pkg::QUEUE_DEPTH_DEF,
   parameter int NEST_DEPTH  = nptd_pkg::NEST_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_kind,
   input  wire logic [nptd_pkg::DATA_W-1:0]        req_priority_req,
   input  wire logic [nptd_pkg::DATA_W-1:0]        req_task_id,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_started,
   output logic [nptd_pkg::DATA_W-1:0]             rsp_started_id,
   output logic [nptd_pkg::DATA_W-1:0]             rsp_started_priority,
   output logic [nptd_pkg::COUNT_OUT_W-1:0]        rsp_nest_level,
   output logic [nptd_pkg::COUNT_OUT_W-1:0]        rsp_pending_count,
   output logic [nptd_pkg::STATUS_W-1:0]           rsp_status
);

   localparam int QW = $clog2(QUEUE_DEPTH + 1);
   localparam int NW = $clog2(NEST_DEPTH + 1);

   nptd_pkg::state_type state_ff, state_in;
   logic [QW-1:0] pending_ff, pending_in;
   logic [NW-1:0] depth_ff, depth_in;
   logic [nptd_pkg::STATUS_W-1:0] status_ff, status_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_started_ff, rsp_started_in;
   logic [nptd_pkg::DATA_W-1:0] rsp_id_ff, rsp_id_in;
   logic [nptd_pkg::DATA_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic [nptd_pkg::COUNT_OUT_W-1:0] rsp_nest_ff, rsp_nest_in;
   logic [nptd_pkg::COUNT_OUT_W-1:0] rsp_pend_ff, rsp_pend_in;
   logic [nptd_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   nptd_pkg::queue_ctl_type q_ctl;
   nptd_pkg::cell_op_type   s_op;
   nptd_pkg::entry_type     new_entry;
   nptd_pkg::entry_type     q_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]  q_after;
   logic [QUEUE_DEPTH-1:0]  q_occ;
   logic [nptd_pkg::DATA_W-1:0] s_prio [NEST_DEPTH];
   logic go;

   assign new_entry.prio = req_priority_req;
   assign new_entry.id   = req_task_id;

   // queue cell chain
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_queue
      nptd_pkg::entry_type left_e, right_e;
      logic left_a;
      assign q_occ[i] = (pending_ff > QW'(i));
      if (i == 0) begin : g_first
         assign left_e = new_entry;
         assign left_a = 1'b1;
      end else begin : g_mid
         assign left_e = q_entry[i-1];
         assign left_a = q_after[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = q_entry[i+1];
      end
      nptd_queue_cell u_cell (
         .clock      (clock),
         .ctl        (q_ctl),
         .new_entry  (new_entry),
         .occupied   (q_occ[i]),
         .left_after (left_a),
         .left_entry (left_e),
         .right_entry(right_e),
         .entry      (q_entry[i]),
         .after      (q_after[i])
      );
   end

   // stack cell chain, pushes take the queue head priority
   for (genvar j = 0; j < NEST_DEPTH; j++) begin : g_stack
      logic [nptd_pkg::DATA_W-1:0] left_p, right_p;
      if (j == 0) begin : g_first
         assign left_p = q_entry[0].prio;
      end else begin : g_mid
         assign left_p = s_prio[j-1];
      end
      if (j == NEST_DEPTH - 1) begin : g_last
         assign right_p = '0;
      end else begin : g_inner
         assign right_p = s_prio[j+1];
      end
      nptd_stack_cell u_cell (
         .clock     (clock),
         .op        (s_op),
         .left_prio (left_p),
         .right_prio(right_p),
         .prio      (s_prio[j])
      );
   end

   assign go = (pending_ff != '0) && (depth_ff < NW'(NEST_DEPTH)) &&
               ((depth_ff == '0) || (q_entry[0].prio < s_prio[0]));

   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      depth_in      = depth_ff;
      status_in     = status_ff;
      q_ctl.op      = nptd_pkg::OP_HOLD;
      q_ctl.new_prio = req_priority_req;
      s_op          = nptd_pkg::OP_HOLD;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_started_in = rsp_started_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_nest_in   = rsp_nest_ff;
      rsp_pend_in   = rsp_pend_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         nptd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = nptd_pkg::ST_START;
               if (req_kind == nptd_pkg::KIND_ADD) begin
                  if (pending_ff < QW'(QUEUE_DEPTH)) begin
                     q_ctl.op   = nptd_pkg::OP_SHIFT_IN;
                     pending_in = pending_ff + QW'(1);
                     status_in  = nptd_pkg::STATUS_OK;
                  end else begin
                     status_in  = nptd_pkg::STATUS_DROPPED;
                  end
               end else begin
                  if (depth_ff == '0) begin
                     status_in = nptd_pkg::STATUS_IDLE_FINISH;
                  end else begin
                     s_op      = nptd_pkg::OP_SHIFT_OUT;
                     depth_in  = depth_ff - NW'(1);
                     status_in = nptd_pkg::STATUS_OK;
                  end
               end
            end
         end
         nptd_pkg::ST_START: begin
            // wait until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in       = nptd_pkg::ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_started_in = go;
               rsp_id_in      = '0;
               rsp_prio_in    = '0;
               if (go) begin
                  q_ctl.op    = nptd_pkg::OP_SHIFT_OUT;
                  s_op        = nptd_pkg::OP_SHIFT_IN;
                  pending_in  = pending_ff - QW'(1);
                  depth_in    = depth_ff + NW'(1);
                  rsp_id_in   = q_entry[0].id;
                  rsp_prio_in = q_entry[0].prio;
               end
               rsp_nest_in   = nptd_pkg::COUNT_OUT_W'(depth_in);
               rsp_pend_in   = nptd_pkg::COUNT_OUT_W'(pending_in);
               rsp_status_in = status_ff;
            end
         end
         default: begin
            state_in = nptd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nptd_pkg::ST_IDLE;
         pending_ff   <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      rsp_started_ff <= rsp_started_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_prio_ff    <= rsp_prio_in;
      rsp_nest_ff    <= rsp_nest_in;
      rsp_pend_ff    <= rsp_pend_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_stall            = (state_ff != nptd_pkg::ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_started          = rsp_started_ff;
   assign rsp_started_id       = rsp_id_ff;
   assign rsp_started_priority = rsp_prio_ff;
   assign rsp_nest_level       = rsp_nest_ff;
   assign rsp_pending_count    = rsp_pend_ff;
   assign rsp_status           = rsp_status_ff;

endmodule

`default_nettype wire

@@ hdl/nptd_checker.sv @@
// port-level checks of the dispatcher and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module nptd_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic                               rsp_started,
   input wire logic [nptd_pkg::DATA_W-1:0]        rsp_started_id,
   input wire logic [nptd_pkg::DATA_W-1:0]        rsp_started_priority,
   input wire logic [nptd_pkg::STATUS_W-1:0]      rsp_status
);

   // no result comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an accepted transaction keeps the input side busy for its start check
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again without a start check");

   // with no start the identifier and priority read zero
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_started) |->
         (rsp_started_id == '0) && (rsp_started_priority == '0))
      else $error("start fields nonzero without a start");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == nptd_pkg::STATUS_OK) ||
                    (rsp_status == nptd_pkg::STATUS_DROPPED) ||
                    (rsp_status == nptd_pkg::STATUS_IDLE_FINISH))
      else $error("undefined status code");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_started_id) &&
                                   $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind nested_priority_task_dispatcher nptd_checker u_nptd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_started         (rsp_started),
   .rsp_started_id      (rsp_started_id),
   .rsp_started_priority(rsp_started_priority),
   .rsp_status          (rsp_status)
);

`default_nettype wire

@@ dv/nested_priority_task_dispatcher_tb.sv @@
// self-checking testbench for the nested priority task dispatcher
`timescale 1ns / 1ps

module nested_priority_task_dispatcher_tb;

   localparam int QDEPTH    = nptd_pkg::QUEUE_DEPTH_DEF;
   localparam int NDEPTH    = nptd_pkg::NEST_DEPTH_DEF;
   localparam int DW        = nptd_pkg::DATA_W;
   localparam int CW        = nptd_pkg::COUNT_OUT_W;
   localparam int SW        = nptd_pkg::STATUS_W;
   localparam int PHASE_LEN = 175;
   localparam int LONG_HOLD = 40;

   typedef struct packed {
      logic          started;
      logic [DW-1:0] started_id;
      logic [DW-1:0] started_priority;
      logic [CW-1:0] nest_level;
      logic [CW-1:0] pending_count;
      logic [SW-1:0] status;
   } dispatch_result_type;

   // one table row; typed rows carry their own expected result
   typedef struct packed {
      logic                kind;
      logic [DW-1:0]       prio;
      logic [DW-1:0]       id;
      logic                typed;
      dispatch_result_type res;
   } event_row_type;

   typedef enum int {
      BURST_MIXED,
      BURST_FILL,
      BURST_CLIMB,
      BURST_DRAIN
   } burst_kind_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_kind = nptd_pkg::KIND_ADD;
   logic [DW-1:0] req_priority_req = '0;
   logic [DW-1:0] req_task_id = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_started;
   logic [DW-1:0] rsp_started_id;
   logic [DW-1:0] rsp_started_priority;
   logic [CW-1:0] rsp_nest_level;
   logic [CW-1:0] rsp_pending_count;
   logic [SW-1:0] rsp_status;

   // dispatcher state as seen by the predictor
   logic [DW-1:0] queued_prio [QDEPTH];
   logic [DW-1:0] queued_id [QDEPTH];
   int            queued_total = 0;
   logic [DW-1:0] running_prio [NDEPTH];
   int            running_depth = 0;

   event_row_type       offered_q [$];
   dispatch_result_type awaited_q [$];
   event_row_type       plan [$];
   int                  fail_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   logic                hold_trigger = 1'b0;

   nested_priority_task_dispatcher dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_priority_req     (req_priority_req),
      .req_task_id          (req_task_id),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_started          (rsp_started),
      .rsp_started_id       (rsp_started_id),
      .rsp_started_priority (rsp_started_priority),
      .rsp_nest_level       (rsp_nest_level),
      .rsp_pending_count    (rsp_pending_count),
      .rsp_status           (rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

   // applies one event to the predicted state and returns the result it causes
   function automatic dispatch_result_type dispatch_event(logic kind, logic [DW-1:0] prio,
                                                          logic [DW-1:0] id);
      dispatch_result_type r;
      int                  pos;
      logic [DW-1:0]       head;
      r = '0;
      r.status = nptd_pkg::STATUS_OK;
      if (kind == nptd_pkg::KIND_ADD) begin
         if (queued_total >= QDEPTH) begin
            r.status = nptd_pkg::STATUS_DROPPED;
         end else begin
            pos = 0;
            while (pos < queued_total && queued_prio[pos] <= prio) pos++;
            for (int k = queued_total; k > pos; k--) begin
               queued_prio[k] = queued_prio[k-1];
               queued_id[k]   = queued_id[k-1];
            end
            queued_prio[pos] = prio;
            queued_id[pos]   = id;
            queued_total++;
         end
      end else if (running_depth == 0) begin
         r.status = nptd_pkg::STATUS_IDLE_FINISH;
      end else begin
         running_depth--;
      end
      if (queued_total > 0 && running_depth < NDEPTH) begin
         head = queued_prio[0];
         if (running_depth == 0 || head < running_prio[running_depth-1]) begin
            r.started          = 1'b1;
            r.started_id       = queued_id[0];
            r.started_priority = head;
            running_prio[running_depth] = head;
            running_depth++;
            for (int k = 1; k < queued_total; k++) begin
               queued_prio[k-1] = queued_prio[k];
               queued_id[k-1]   = queued_id[k];
            end
            queued_total--;
         end
      end
      r.nest_level    = CW'(running_depth);
      r.pending_count = CW'(queued_total);
      return r;
   endfunction

   task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // both channels are sampled here, results before new transactions
   always @(posedge clock) begin : monitor
      dispatch_result_type exp_res;
      dispatch_result_type pred;
      event_row_type       row;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_q.size() == 0) begin
               $error("rsp transaction with no expectation pending");
               fail_count++;
            end else begin
               exp_res = awaited_q.pop_front();
               check_field("started", exp_res.started, rsp_started);
               check_field("started_id", exp_res.started_id, rsp_started_id);
               check_field("started_priority", exp_res.started_priority,
                           rsp_started_priority);
               check_field("nest_level", exp_res.nest_level, rsp_nest_level);
               check_field("pending_count", exp_res.pending_count, rsp_pending_count);
               check_field("status", exp_res.status, rsp_status);
            end
         end
         if (req_valid && !req_stall) begin
            row  = offered_q.pop_front();
            pred = dispatch_event(req_kind, req_priority_req, req_task_id);
            awaited_q.push_back(row.typed ? row.res : pred);
         end
      end
   end

   // receiver: random stalls, plus a long hold-off whenever the trigger toggles
   initial begin : receiver
      int unsigned hold_left;
      logic        seen_trigger;
      hold_left    = 0;
      seen_trigger = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger != seen_trigger) begin
            seen_trigger = hold_trigger;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic plan_row(logic kind, int prio, int id);
      event_row_type row;
      row      = '0;
      row.kind = kind;
      row.prio = DW'(prio);
      row.id   = DW'(id);
      plan.push_back(row);
   endtask

   task automatic plan_typed(logic kind, int prio, int id, logic started, int sid,
                             int sprio, int nest, int pend, logic [SW-1:0] status);
      event_row_type row;
      row.kind                 = kind;
      row.prio                 = DW'(prio);
      row.id                   = DW'(id);
      row.typed                = 1'b1;
      row.res.started          = started;
      row.res.started_id       = DW'(sid);
      row.res.started_priority = DW'(sprio);
      row.res.nest_level       = CW'(nest);
      row.res.pending_count    = CW'(pend);
      row.res.status           = status;
      plan.push_back(row);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_event(event_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= row.kind;
      req_priority_req <= row.prio;
      req_task_id      <= row.id;
      offered_q.push_back(row);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      event_row_type  row;
      burst_kind_type burst;
      int             pick;
      int             left;
      int             climb;
      row = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 6;
      recv_idle_pct <= 54;

      plan_typed(nptd_pkg::KIND_FINISH, 0, 0, 1'b0, 0, 0, 0, 0,
                 nptd_pkg::STATUS_IDLE_FINISH);
      plan_typed(nptd_pkg::KIND_ADD, 255, 255, 1'b1, 255, 255, 1, 0, nptd_pkg::STATUS_OK);
      // strictly falling priorities nest until the stack is full
      plan_row(nptd_pkg::KIND_ADD, 254, 8'h01);
      plan_row(nptd_pkg::KIND_ADD, 253, 8'h02);
      plan_row(nptd_pkg::KIND_ADD, 252, 8'h04);
      plan_row(nptd_pkg::KIND_ADD, 251, 8'h08);
      plan_row(nptd_pkg::KIND_ADD, 250, 8'h10);
      plan_row(nptd_pkg::KIND_ADD, 249, 8'h20);
      plan_row(nptd_pkg::KIND_ADD, 248, 8'h40);
      plan_row(nptd_pkg::KIND_ADD, 247, 8'h80);
      plan_row(nptd_pkg::KIND_ADD, 246, 8'h11);
      plan_row(nptd_pkg::KIND_ADD, 245, 8'h22);
      plan_row(nptd_pkg::KIND_ADD, 244, 8'h33);
      plan_row(nptd_pkg::KIND_ADD, 243, 8'h44);
      plan_row(nptd_pkg::KIND_ADD, 242, 8'h66);
      plan_row(nptd_pkg::KIND_ADD, 241, 8'h77);
      plan_row(nptd_pkg::KIND_ADD, 240, 8'h99);
      // stack full: both stay queued, the urgent one ahead
      plan_row(nptd_pkg::KIND_ADD, 240, 8'hC3);
      plan_row(nptd_pkg::KIND_ADD, 0, 8'h00);
      plan_row(nptd_pkg::KIND_FINISH, 0, 0);
      // equal priorities leave in arrival order
      plan_row(nptd_pkg::KIND_ADD, 0, 8'hAA);
      plan_row(nptd_pkg::KIND_ADD, 0, 8'h55);
      plan_row(nptd_pkg::KIND_FINISH, 8'hFF, 8'hFF);
      plan_row(nptd_pkg::KIND_FINISH, 0, 0);
      // head blocked by a more urgent running task
      plan_row(nptd_pkg::KIND_ADD, 241, 8'h5A);

      foreach (plan[i]) send_event(plan[i]);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 6;
               recv_idle_pct <= 54;
            end
            1: begin
               send_idle_pct <= 54;
               recv_idle_pct <= 6;
            end
            default: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
               hold_trigger  <= ~hold_trigger;
            end
         endcase
         left = PHASE_LEN;
         while (left > 0) begin
            pick = $urandom_range(99);
            burst = (pick < 20) ? BURST_MIXED : (pick < 50) ? BURST_FILL :
                    (pick < 75) ? BURST_CLIMB : BURST_DRAIN;
            climb = 255;
            repeat ($urandom_range(24, 8)) begin
               row.prio = DW'($urandom);
               row.id   = DW'($urandom);
               case (burst)
                  BURST_MIXED: row.kind = 1'($urandom_range(1));
                  BURST_FILL: begin
                     row.kind = ($urandom_range(99) < 10) ? nptd_pkg::KIND_FINISH :
                                                           nptd_pkg::KIND_ADD;
                     row.prio = DW'($urandom_range(255, 96));
                  end
                  BURST_CLIMB: begin
                     row.kind = ($urandom_range(99) < 15) ? nptd_pkg::KIND_FINISH :
                                                           nptd_pkg::KIND_ADD;
                     climb = climb - int'($urandom_range(20, 1));
                     if (climb < 0) climb = 255;
                     row.prio = DW'(climb);
                  end
                  default: row.kind = ($urandom_range(99) < 85) ? nptd_pkg::KIND_FINISH :
                                                                 nptd_pkg::KIND_ADD;
               endcase
               send_event(row);
               left--;
            end
         end
      end
      req_valid <= 1'b0;

      while (awaited_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
